// ===== sv/bkt_pkg.sv =====
// shared types, codes and constants of the knot table
package bkt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_MAX_DEGREE  = 7;
    localparam int DEF_KNOT_BITS   = 32;

    localparam int KIND_W     = 3;
    localparam int COUNT_W    = 3;
    localparam int STATUS_W   = 2;
    localparam int SPAN_W     = 9;
    localparam int MULT_OUT_W = 3;
    localparam int TOTAL_W    = 9;
    localparam int UNIQUE_W   = 7;
    localparam int OUT_DATA_W = 32;

    localparam int DEGREE_W = 3;
    localparam int TOL_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 3'd3;
    localparam logic [TOL_W-1:0]    TOL_RESET    = 16'd1;

    typedef struct packed {
        logic lt;
        logic gt;
        logic near;
        logic far;
    } cmp_res_t;

endpackage

// ===== sv/bkt_cmp.sv =====
// shared knot compare unit: order and distance against tolerance
module bkt_cmp #(
    parameter int KNOT_BITS = bkt_pkg::DEF_KNOT_BITS
) (
    input  logic signed [KNOT_BITS-1:0] a,
    input  logic signed [KNOT_BITS-1:0] b,
    input  logic [bkt_pkg::TOL_W-1:0]   tol,
    output bkt_pkg::cmp_res_t           res
);

    logic [KNOT_BITS-1:0] abs_diff;
    logic [KNOT_BITS-1:0] tol_ext;

    always_comb
    begin
        tol_ext = KNOT_BITS'(tol);
        if (a >= b)
        begin
            abs_diff = KNOT_BITS'(a - b);
        end
        else
        begin
            abs_diff = KNOT_BITS'(b - a);
        end
        res.lt   = (a < b);
        res.gt   = (a > b);
        res.near = (abs_diff < tol_ext);
        res.far  = (abs_diff > tol_ext);
    end

endmodule

// ===== sv/bspline_knot_table.sv =====
// knot table top level: sequencer, knot memory and result register
//
//  channel  | signals                         | contents
//  ---------+---------------------------------+---------------------------------
//  s_axis   | tvalid tready tdata tuser       | operation on the table
//  m_axis   | tvalid tready tdata tuser       | status and table counts
//  cfg      | valid ready index data          | degree, tolerance writes
//
// one transaction at a time; find span, insert, remove and delete walk the
// table one memory entry at a time through a single read port (a read
// state, then a use state, per entry visited)
// insert, remove and delete may shift entries, then rescan the table to rebuild the sum
// reset empties the table; memory contents are not cleared
// a finished result waits in the output register while the next one is taken
module bspline_knot_table #(
    parameter int TABLE_DEPTH = bkt_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_DEGREE  = bkt_pkg::DEF_MAX_DEGREE,
    parameter int KNOT_BITS   = bkt_pkg::DEF_KNOT_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // knot_value, count, zero pad
    input  logic [((KNOT_BITS + bkt_pkg::COUNT_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // kind
    input  logic [bkt_pkg::KIND_W-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // span_index, multiplicity, total_knots, unique_knots, zero pad
    output logic [bkt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [bkt_pkg::STATUS_W-1:0] m_axis_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [bkt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bkt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = $clog2(MAX_DEGREE + 1);
    localparam int EW = $clog2(TABLE_DEPTH * MAX_DEGREE + 1);
    localparam int SW = EW + 2;
    localparam int WW = MW + KNOT_BITS;
    localparam int XW = MW + 3;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RD0  = 5'd1;
    localparam logic [4:0] ST_US0  = 5'd2;
    localparam logic [4:0] ST_RDL  = 5'd3;
    localparam logic [4:0] ST_USL  = 5'd4;
    localparam logic [4:0] ST_SCR  = 5'd5;
    localparam logic [4:0] ST_SCU  = 5'd6;
    localparam logic [4:0] ST_CALC = 5'd7;
    localparam logic [4:0] ST_SLR  = 5'd8;
    localparam logic [4:0] ST_SLU  = 5'd9;
    localparam logic [4:0] ST_DEC  = 5'd10;
    localparam logic [4:0] ST_SHR  = 5'd11;
    localparam logic [4:0] ST_SHU  = 5'd12;
    localparam logic [4:0] ST_PUT  = 5'd13;
    localparam logic [4:0] ST_FX0  = 5'd14;
    localparam logic [4:0] ST_FXR  = 5'd15;
    localparam logic [4:0] ST_FXU  = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;

    logic [WW-1:0] mem [TABLE_DEPTH];
    logic [WW-1:0] rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [WW-1:0] wdata;
    logic [AW-1:0] raddr;

    logic [4:0] state_reg, state_next;
    logic [bkt_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic signed [KNOT_BITS-1:0] u_reg, u_next;
    logic [bkt_pkg::COUNT_W-1:0] c_reg, c_next;
    logic [NW-1:0] n_reg, n_next;
    logic [EW-1:0] exp_reg, exp_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [EW-1:0] le_reg, le_next;
    logic [NW-1:0] lt_reg, lt_next;
    logic [EW-1:0] cum_reg, cum_next;
    logic [EW-1:0] s_reg, s_next;
    logic found_reg, found_next;
    logic slot_ok_reg, slot_ok_next;
    logic [NW-1:0] slot_reg, slot_next;
    logic [MW-1:0] slot_mult_reg, slot_mult_next;
    logic signed [KNOT_BITS-1:0] slot_knot_reg, slot_knot_next;
    logic up_reg, up_next;
    logic clamp_reg, clamp_next;
    logic [EW-1:0] sum_reg, sum_next;
    logic [bkt_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [MW-1:0] mult_reg, mult_next;
    logic [bkt_pkg::DEGREE_W-1:0] degree_reg;
    logic [bkt_pkg::TOL_W-1:0] tol_reg;
    logic m_valid_reg;
    logic [bkt_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [bkt_pkg::STATUS_W-1:0] m_user_reg;
    logic load_out;

    logic [3:0] d4;
    logic [MW-1:0] d_eff;
    logic signed [KNOT_BITS-1:0] rd_knot;
    logic [MW-1:0] rd_mult;
    bkt_pkg::cmp_res_t cmp;
    logic [NW-1:0] n_last;
    logic signed [SW-1:0] le_s, hi_s, lo_s, em1_s, s_cl;
    logic [XW-1:0] c_ext, d_ext, sum_x;
    logic [MW-1:0] m_fix;

    bkt_cmp #(
        .KNOT_BITS(KNOT_BITS)
    ) u_cmp (
        .a   (u_reg),
        .b   (rd_knot),
        .tol (tol_reg),
        .res (cmp)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign rd_knot = $signed(rdata_reg[KNOT_BITS-1:0]);
    assign rd_mult = rdata_reg[WW-1:KNOT_BITS];
    assign n_last  = n_reg - NW'(1);

    always_comb
    begin
        d4 = {1'b0, degree_reg};
        if (d4 == 4'd0)
        begin
            d4 = 4'd1;
        end
        if (d4 > 4'(MAX_DEGREE))
        begin
            d4 = 4'(MAX_DEGREE);
        end
        d_eff = d4[MW-1:0];
    end

    always_comb
    begin
        le_s  = $signed({2'b00, le_reg}) - $signed(SW'(1));
        hi_s  = $signed({2'b00, exp_reg}) - $signed(SW'(d_eff)) - $signed(SW'(1));
        lo_s  = $signed(SW'(d_eff)) - $signed(SW'(1));
        em1_s = $signed({2'b00, exp_reg}) - $signed(SW'(1));
        s_cl  = le_s;
        if (s_cl > hi_s)
        begin
            s_cl = hi_s;
        end
        if (s_cl < lo_s)
        begin
            s_cl = lo_s;
        end
        if (s_cl > em1_s)
        begin
            s_cl = em1_s;
        end
        if (s_cl < $signed(SW'(0)))
        begin
            s_cl = '0;
        end
    end

    assign c_ext = XW'(c_reg);
    assign d_ext = XW'(d_eff);
    assign sum_x = XW'(slot_mult_reg) + c_ext;

    always_comb
    begin
        m_fix = rd_mult;
        if (clamp_reg)
        begin
            if (idx_reg == NW'(0) || idx_reg == n_last)
            begin
                m_fix = d_eff;
            end
            else if (rd_mult > d_eff)
            begin
                m_fix = d_eff;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        u_next         = u_reg;
        c_next         = c_reg;
        n_next         = n_reg;
        exp_next       = exp_reg;
        idx_next       = idx_reg;
        le_next        = le_reg;
        lt_next        = lt_reg;
        cum_next       = cum_reg;
        s_next         = s_reg;
        found_next     = found_reg;
        slot_ok_next   = slot_ok_reg;
        slot_next      = slot_reg;
        slot_mult_next = slot_mult_reg;
        slot_knot_next = slot_knot_reg;
        up_next        = up_reg;
        clamp_next     = clamp_reg;
        sum_next       = sum_reg;
        status_next    = status_reg;
        mult_next      = mult_reg;
        we             = 1'b0;
        waddr          = idx_reg[AW-1:0];
        wdata          = rdata_reg;
        raddr          = idx_reg[AW-1:0];
        load_out       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next    = s_axis_tuser;
                    u_next       = $signed(s_axis_tdata[KNOT_BITS-1:0]);
                    c_next       = s_axis_tdata[KNOT_BITS +: bkt_pkg::COUNT_W];
                    if (s_axis_tdata[KNOT_BITS +: bkt_pkg::COUNT_W] == '0)
                    begin
                        c_next = bkt_pkg::COUNT_W'(1);
                    end
                    status_next  = bkt_pkg::STAT_OK;
                    s_next       = '0;
                    mult_next    = '0;
                    found_next   = 1'b0;
                    slot_ok_next = 1'b0;
                    lt_next      = '0;
                    if (s_axis_tuser == bkt_pkg::KIND_CLEAR)
                    begin
                        n_next     = '0;
                        exp_next   = '0;
                        state_next = ST_OUT;
                    end
                    else if (s_axis_tuser > bkt_pkg::KIND_CLEAR)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (n_reg == '0)
                    begin
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        state_next = ST_RD0;
                    end
                end
            end
            ST_RD0:
            begin
                raddr      = '0;
                state_next = ST_US0;
            end
            ST_US0:
            begin
                if (cmp.lt && cmp.far)
                begin
                    lt_next    = '0;
                    state_next = ST_DEC;
                end
                else
                begin
                    state_next = ST_RDL;
                end
            end
            ST_RDL:
            begin
                raddr      = n_last[AW-1:0];
                state_next = ST_USL;
            end
            ST_USL:
            begin
                if (cmp.gt && cmp.far)
                begin
                    lt_next    = n_reg;
                    state_next = ST_DEC;
                end
                else if (cmp.near)
                begin
                    found_next     = 1'b1;
                    slot_ok_next   = 1'b1;
                    slot_next      = n_last;
                    slot_mult_next = rd_mult;
                    slot_knot_next = rd_knot;
                    s_next         = (hi_s < $signed(SW'(0))) ? '0 : hi_s[EW-1:0];
                    state_next     = ST_DEC;
                end
                else
                begin
                    idx_next   = '0;
                    le_next    = '0;
                    lt_next    = '0;
                    state_next = ST_SCR;
                end
            end
            ST_SCR:
            begin
                state_next = ST_SCU;
            end
            ST_SCU:
            begin
                if (!cmp.lt)
                begin
                    le_next = le_reg + EW'(rd_mult);
                end
                if (cmp.gt)
                begin
                    lt_next = lt_reg + NW'(1);
                end
                if (idx_reg == n_last)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    idx_next   = idx_reg + NW'(1);
                    state_next = ST_SCR;
                end
            end
            ST_CALC:
            begin
                s_next     = s_cl[EW-1:0];
                idx_next   = '0;
                cum_next   = '0;
                state_next = ST_SLR;
            end
            ST_SLR:
            begin
                state_next = ST_SLU;
            end
            ST_SLU:
            begin
                if (idx_reg == n_last ||
                    ({1'b0, s_reg} < ({1'b0, cum_reg} + (EW + 1)'(rd_mult))))
                begin
                    found_next     = 1'b1;
                    slot_ok_next   = cmp.near;
                    slot_next      = idx_reg;
                    slot_mult_next = rd_mult;
                    slot_knot_next = rd_knot;
                    state_next     = ST_DEC;
                end
                else
                begin
                    cum_next   = cum_reg + EW'(rd_mult);
                    idx_next   = idx_reg + NW'(1);
                    state_next = ST_SLR;
                end
            end
            ST_DEC:
            begin
                case (kind_reg)
                    bkt_pkg::KIND_FIND:
                    begin
                        if (!found_reg)
                        begin
                            status_next = bkt_pkg::STAT_RANGE;
                            s_next      = '0;
                        end
                        else
                        begin
                            mult_next = slot_ok_reg ? slot_mult_reg : '0;
                        end
                        state_next = ST_OUT;
                    end
                    bkt_pkg::KIND_INSERT:
                    begin
                        s_next = '0;
                        if (found_reg && slot_ok_reg)
                        begin
                            we         = 1'b1;
                            waddr      = slot_reg[AW-1:0];
                            wdata      = {(sum_x > d_ext) ? d_eff : sum_x[MW-1:0],
                                          slot_knot_reg};
                            clamp_next = 1'b1;
                            state_next = ST_FX0;
                        end
                        else if (n_reg >= NW'(TABLE_DEPTH))
                        begin
                            status_next = bkt_pkg::STAT_FULL;
                            state_next  = ST_OUT;
                        end
                        else if (n_reg > lt_reg)
                        begin
                            idx_next   = n_last;
                            up_next    = 1'b1;
                            state_next = ST_SHR;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                    bkt_pkg::KIND_REMOVE, bkt_pkg::KIND_DELETE:
                    begin
                        s_next     = '0;
                        clamp_next = 1'b0;
                        if (!(found_reg && slot_ok_reg))
                        begin
                            status_next = bkt_pkg::STAT_NOT_FOUND;
                            state_next  = ST_OUT;
                        end
                        else if (kind_reg == bkt_pkg::KIND_DELETE ||
                                 c_ext >= XW'(slot_mult_reg))
                        begin
                            if ((slot_reg + NW'(1)) < n_reg)
                            begin
                                idx_next   = slot_reg + NW'(1);
                                up_next    = 1'b0;
                                state_next = ST_SHR;
                            end
                            else
                            begin
                                n_next     = n_last;
                                state_next = ST_FX0;
                            end
                        end
                        else
                        begin
                            we         = 1'b1;
                            waddr      = slot_reg[AW-1:0];
                            wdata      = {slot_mult_reg - c_ext[MW-1:0], slot_knot_reg};
                            state_next = ST_FX0;
                        end
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_SHR:
            begin
                state_next = ST_SHU;
            end
            ST_SHU:
            begin
                we    = 1'b1;
                wdata = rdata_reg;
                if (up_reg)
                begin
                    waddr = AW'(idx_reg + NW'(1));
                    if (idx_reg == lt_reg)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - NW'(1);
                        state_next = ST_SHR;
                    end
                end
                else
                begin
                    waddr = AW'(idx_reg - NW'(1));
                    if (idx_reg == n_last)
                    begin
                        n_next     = n_last;
                        state_next = ST_FX0;
                    end
                    else
                    begin
                        idx_next   = idx_reg + NW'(1);
                        state_next = ST_SHR;
                    end
                end
            end
            ST_PUT:
            begin
                we         = 1'b1;
                waddr      = lt_reg[AW-1:0];
                wdata      = {(c_ext > d_ext) ? d_eff : c_ext[MW-1:0], u_reg};
                n_next     = n_reg + NW'(1);
                clamp_next = 1'b1;
                state_next = ST_FX0;
            end
            ST_FX0:
            begin
                idx_next = '0;
                sum_next = '0;
                if (n_reg == '0)
                begin
                    exp_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_FXR;
                end
            end
            ST_FXR:
            begin
                state_next = ST_FXU;
            end
            ST_FXU:
            begin
                we       = clamp_reg;
                wdata    = {m_fix, rd_knot};
                sum_next = sum_reg + EW'(m_fix);
                if (idx_reg == n_last)
                begin
                    exp_next   = sum_reg + EW'(m_fix);
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + NW'(1);
                    state_next = ST_FXR;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            exp_reg     <= '0;
            degree_reg  <= bkt_pkg::DEGREE_RESET;
            tol_reg     <= bkt_pkg::TOL_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            exp_reg   <= exp_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bkt_pkg::REG_DEGREE:
                    begin
                        degree_reg <= cfg_data[bkt_pkg::DEGREE_W-1:0];
                    end
                    bkt_pkg::REG_TOLERANCE:
                    begin
                        tol_reg <= cfg_data[bkt_pkg::TOL_W-1:0];
                    end
                    default:
                    begin
                        degree_reg <= degree_reg;
                    end
                endcase
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        u_reg         <= u_next;
        c_reg         <= c_next;
        idx_reg       <= idx_next;
        le_reg        <= le_next;
        lt_reg        <= lt_next;
        cum_reg       <= cum_next;
        s_reg         <= s_next;
        found_reg     <= found_next;
        slot_ok_reg   <= slot_ok_next;
        slot_reg      <= slot_next;
        slot_mult_reg <= slot_mult_next;
        slot_knot_reg <= slot_knot_next;
        up_reg        <= up_next;
        clamp_reg     <= clamp_next;
        sum_reg       <= sum_next;
        status_reg    <= status_next;
        mult_reg      <= mult_next;
        if (load_out)
        begin
            m_user_reg <= status_reg;
            m_data_reg <= {4'b0000,
                           bkt_pkg::UNIQUE_W'(n_reg),
                           bkt_pkg::TOTAL_W'(exp_reg),
                           bkt_pkg::MULT_OUT_W'(mult_reg),
                           bkt_pkg::SPAN_W'(s_reg)};
        end
    end

endmodule
